FILE: rtl/core/mpq_pkg.sv
// Package: shared types, request codes and crypt table function for the MPQ hash engine.
`timescale 1ns / 1ps
`default_nettype none
package mpq_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
  localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;
  localparam logic [31:0] LCG_INIT      = 32'h00100001;
  localparam logic [31:0] LCG_MOD       = 32'h002AAAAB;
  localparam int          CRYPT_DEPTH   = 768;

  typedef logic [31:0] word_t;

  // hash results handed from the hash unit to the probe sequencer
  typedef struct packed {
    word_t      off;
    word_t      chk_a;
    word_t      chk_b;
    logic [1:0] req;
  } hash_res_t;

  // one LCG step; state stays below the modulus, so the quotient is below 128
  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    logic [63:0] p;
    p = {32'd0, s} * 64'd125 + 64'd3;
    for (int k = 6; k >= 0; k--) begin
      if (p >= ({32'd0, LCG_MOD} << k)) p = p - ({32'd0, LCG_MOD} << k);
    end
    return 32'(p);
  endfunction

  // crypt table rows 0 to 2 (768 entries), evaluated at elaboration only
  typedef logic [31:0] crypt_arr_t [CRYPT_DEPTH];
  function automatic crypt_arr_t build_crypt();
    crypt_arr_t rom;
    logic [31:0] s;
    logic [31:0] hi;
    s = LCG_INIT;
    for (int col = 0; col < 256; col++) begin
      for (int row = 0; row < 5; row++) begin
        s  = lcg_next(s);
        hi = (s & 32'hFFFF) << 16;
        s  = lcg_next(s);
        if (row < 3) rom[row * 256 + col] = hi | (s & 32'hFFFF);
      end
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mpq_hash.sv
// Hash unit: folds key bytes and runs the three MPQ hash chains, one byte per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mpq_hash (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                byte_vld,
  input  wire  [7:0]         key_byte,
  input  wire                last_byte,
  input  wire  [1:0]         req_type,
  output logic               res_vld,
  output mpq_pkg::hash_res_t res
);
  import mpq_pkg::*;

  localparam crypt_arr_t CRYPT = build_crypt();

  logic [31:0] s1_r [3];
  logic [31:0] s2_r [3];
  logic [31:0] s1_n [3];
  logic [31:0] s2_n [3];
  logic [7:0]  ch;
  logic        res_vld_r;
  hash_res_t   res_r;

  // upper-case fold
  always_comb begin
    ch = key_byte;
    if (key_byte >= 8'h61 && key_byte <= 8'h7A) ch = key_byte - 8'h20;
  end

  // three independent hash lanes
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      s1_n[t] = CRYPT[t * 256 + int'(ch)] ^ (s1_r[t] + s2_r[t]);
      s2_n[t] = {24'd0, ch} + s1_n[t] + s2_r[t] + (s2_r[t] << 5) + 32'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < 3; t++) begin
        s1_r[t] <= SEED_ONE_INIT;
        s2_r[t] <= SEED_TWO_INIT;
      end
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= byte_vld && last_byte && (req_type != REQ_NONE);
      if (byte_vld) begin
        for (int t = 0; t < 3; t++) begin
          s1_r[t] <= last_byte ? SEED_ONE_INIT : s1_n[t];
          s2_r[t] <= last_byte ? SEED_TWO_INIT : s2_n[t];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld && last_byte) begin
      res_r.off   <= s1_n[0];
      res_r.chk_a <= s1_n[1];
      res_r.chk_b <= s1_n[2];
      res_r.req   <= req_type;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;
endmodule
`default_nettype wire

FILE: rtl/core/mpq_probe.sv
// Probe sequencer: serial modulo, then a linear probe walk over the slot store.
`timescale 1ns / 1ps
`default_nettype none
module mpq_probe #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire  [10:0]        table_size,
  input  wire                go,
  input  mpq_pkg::hash_res_t hres,
  output logic               busy,
  output logic               done,
  output logic [9:0]         pos_out,
  output logic               found_out,
  output logic               full_out
);
  import mpq_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = AW + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;

  logic [2:0]    st_r;
  logic [NW-1:0] n_r;
  logic [31:0]   rem_r;
  logic [5:0]    bit_r;
  logic [31:0]   dvd_r;
  logic [AW-1:0] home_r, pos_r;
  logic [31:0]   ca_r, cb_r;
  logic [1:0]    req_r;
  logic          done_r, found_r, full_r;
  logic [9:0]    opos_r;
  logic [AW-1:0] clr_r;

  // slot store: valid bits cleared by a pass after reset
  logic          vmem [TABLE_DEPTH];
  logic [31:0]   amem [TABLE_DEPTH];
  logic [31:0]   bmem [TABLE_DEPTH];
  logic          v_q;
  logic [31:0]   a_q, b_q;

  logic          we;
  logic [AW-1:0] wa;
  logic          wv;
  logic [31:0]   wda, wdb;

  logic [NW-1:0] n_eff;
  logic [32:0]   trial;
  logic [NW-1:0] pos_inc;
  logic [AW-1:0] pos_nx;

  always_comb begin
    if (table_size == 11'd0) n_eff = NW'(1);
    else if ({21'd0, table_size} > 32'(TABLE_DEPTH)) n_eff = NW'(TABLE_DEPTH);
    else n_eff = NW'(table_size);
  end

  // restoring divider step: remainder only
  assign trial = {rem_r, dvd_r[31]} - {{(33-NW){1'b0}}, n_r};

  assign pos_inc = {1'b0, pos_r} + NW'(1);
  assign pos_nx  = (pos_inc == n_r) ? '0 : pos_inc[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      vmem[wa] <= wv;
      amem[wa] <= wda;
      bmem[wa] <= wdb;
    end
    v_q <= vmem[pos_r];
    a_q <= amem[pos_r];
    b_q <= bmem[pos_r];
  end

  // write port select
  always_comb begin
    we  = 1'b0;
    wa  = pos_r;
    wv  = 1'b0;
    wda = ca_r;
    wdb = cb_r;
    if (st_r == ST_CLEAR) begin
      we = 1'b1;
      wa = clr_r;
    end else if (st_r == ST_CHK) begin
      if (req_r == REQ_INSERT) begin
        if (!v_q || pos_nx == home_r) begin
          we = 1'b1;
          wv = 1'b1;
          wa = v_q ? home_r : pos_r;
        end
      end else if (v_q && a_q == ca_r && b_q == cb_r && req_r == REQ_DELETE) begin
        we  = 1'b1;
        wda = '0;
        wdb = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      clr_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(TABLE_DEPTH - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (go) begin
            st_r  <= ST_MOD;
            n_r   <= n_eff;
            dvd_r <= hres.off;
            rem_r <= '0;
            bit_r <= 6'd0;
            ca_r  <= hres.chk_a;
            cb_r  <= hres.chk_b;
            req_r <= hres.req;
          end
        end
        ST_MOD: begin
          dvd_r <= dvd_r << 1;
          bit_r <= bit_r + 6'd1;
          if (!trial[32]) rem_r <= trial[31:0];
          else rem_r <= {rem_r[30:0], dvd_r[31]};
          if (bit_r == 6'd31) begin
            st_r <= ST_RD;
            home_r <= !trial[32] ? trial[AW-1:0] : AW'({rem_r[30:0], dvd_r[31]});
            pos_r  <= !trial[32] ? trial[AW-1:0] : AW'({rem_r[30:0], dvd_r[31]});
          end
        end
        ST_RD: st_r <= ST_CHK;
        ST_CHK: begin
          if (req_r == REQ_INSERT) begin
            if (!v_q || pos_nx == home_r) begin
              st_r    <= ST_IDLE;
              done_r  <= 1'b1;
              found_r <= 1'b1;
              full_r  <= v_q;
              opos_r  <= 10'(v_q ? home_r : pos_r);
            end else begin
              pos_r <= pos_nx;
              st_r  <= ST_RD;
            end
          end else begin
            if (!v_q || (a_q == ca_r && b_q == cb_r) || pos_nx == home_r) begin
              st_r    <= ST_IDLE;
              done_r  <= 1'b1;
              full_r  <= 1'b0;
              found_r <= v_q && a_q == ca_r && b_q == cb_r;
              opos_r  <= (v_q && a_q == ca_r && b_q == cb_r) ? 10'(pos_r) : 10'd0;
            end else begin
              pos_r <= pos_nx;
              st_r  <= ST_RD;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (st_r != ST_IDLE) || go;
  assign done      = done_r;
  assign pos_out   = opos_r;
  assign found_out = found_r;
  assign full_out  = full_r;
endmodule
`default_nettype wire

FILE: rtl/core/mpq_hash_table_engine.sv
// Top level: MPQ hash table engine with linear probing.
// Usage:
//   Input: drive in_req_type, in_key_byte, in_last_byte with start; a byte
//   is taken at a clock edge with start high and busy low. Mid-key bytes
//   are hashed as taken. The last byte launches the request.
//   After the last byte, a request passes the hash result register, the
//   serial remainder unit for the home slot, then a memory read and a
//   compare for each probed slot in the slot store; busy stays
//   high throughout. Request code 3 gives no result.
//   Result: out_valid pulses one cycle with out_slot_position, out_found,
//   out_table_full. The receiver cannot stall; results are never held.
//   Config: cfg_valid/cfg_ready write table_size; cfg_ready is high while
//   the probe sequencer is idle: not clearing and no request in flight.
//   Reset: rst_n synchronous. After reset a clearing pass over all
//   TABLE_DEPTH slots empties the slot store; busy is high during it.
//   table_size resets to 1024.
`timescale 1ns / 1ps
`default_nettype none
module mpq_hash_table_engine #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  in_req_type,
  input  wire  [7:0]  in_key_byte,
  input  wire         in_last_byte,
  output logic        out_valid,
  output logic [9:0]  out_slot_position,
  output logic        out_found,
  output logic        out_table_full,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [10:0] cfg_table_size
);
  import mpq_pkg::*;

  logic      acc;
  logic      h_vld;
  hash_res_t h_res;
  logic      p_busy;
  logic [10:0] size_r;

  assign acc = start && !busy;
  assign busy = p_busy;

  mpq_hash u_hash (
    .clk(clk), .rst_n(rst_n), .byte_vld(acc), .key_byte(in_key_byte),
    .last_byte(in_last_byte), .req_type(in_req_type),
    .res_vld(h_vld), .res(h_res)
  );

  mpq_probe #(.TABLE_DEPTH(TABLE_DEPTH)) u_probe (
    .clk(clk), .rst_n(rst_n), .table_size(size_r), .go(h_vld), .hres(h_res),
    .busy(p_busy), .done(out_valid), .pos_out(out_slot_position),
    .found_out(out_found), .full_out(out_table_full)
  );

  // size register
  assign cfg_ready = !p_busy;
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 11'd1024;
    else if (cfg_valid && cfg_ready) size_r <= cfg_table_size;
  end
endmodule
`default_nettype wire
